// ----- rtl/pasm_pkg.sv -----
`default_nettype none

package pasm_pkg;

    // Coefficient, result and degree widths
    localparam int COEFF_W = 16;
    localparam int RES_W   = 37;
    localparam int DEG_W   = 6;

    // Operation codes (code three behaves as add)
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // One operation issued into the arithmetic pipeline
    typedef struct packed {
        logic vld;
        logic first;   // opens a new term: load instead of accumulate
        logic last;    // closes the term: result goes to the output register
        logic za;      // force first operand to zero
        logic zb;      // force second operand to zero
    } t_issue;

    // Tags of the term being computed
    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic             last;
        logic             dropped;
    } t_term;

endpackage

`default_nettype wire

// ----- rtl/pasm_coeff_mem.sv -----
`default_nettype none

module pasm_coeff_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [pasm_pkg::COEFF_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                i_raddr,
    output logic      [pasm_pkg::COEFF_W-1:0] o_rdata
);

    logic [pasm_pkg::COEFF_W-1:0] r_mem [DEPTH];
    logic [pasm_pkg::COEFF_W-1:0] r_rdata;

    // Write one coefficient, read one with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/pasm_seq.sv -----
`default_nettype none

module pasm_seq #(
    parameter int MAX_TERMS = 32,
    parameter int AW        = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input request channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_which_operand,
    input  wire logic                         i_is_last,
    // mode and pipeline status
    input  wire logic                         i_mult,
    input  wire logic                         i_out_free,
    input  wire logic                         i_term_done,
    // coefficient memory ports
    output logic                              o_we_a,
    output logic                              o_we_b,
    output logic      [AW-1:0]                o_waddr,
    output logic      [AW-1:0]                o_raddr_a,
    output logic      [AW-1:0]                o_raddr_b,
    // to the arithmetic pipeline
    output pasm_pkg::t_issue                  o_issue,
    output pasm_pkg::t_term                   o_term
);

    localparam int DW = pasm_pkg::DEG_W;

    typedef enum logic [1:0] {
        S_LOAD,
        S_START,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state        r_state, n_state;
    logic [DW-1:0] r_len_a, n_len_a;
    logic [DW-1:0] r_len_b, n_len_b;
    logic          r_overflow, n_overflow;
    logic [DW-1:0] r_k, n_k;
    logic [DW-1:0] r_i, n_i;

    logic [DW-1:0] w_cap;
    logic [DW:0]   w_span;
    logic [DW-1:0] w_kmax;
    logic [DW-1:0] w_lo;
    logic [DW-1:0] w_hi;
    logic [DW-1:0] w_j;
    logic [DW-1:0] w_wlen;
    logic          w_issue_last;

    assign w_cap = DW'(MAX_TERMS);

    // Index of the final result term
    assign w_span = {1'b0, r_len_a} + {1'b0, r_len_b} - (DW+1)'(2);
    always_comb begin
        if (i_mult) begin
            w_kmax = (r_len_a == '0) ? '0 : w_span[DW-1:0];
        end else begin
            w_kmax = ((r_len_a > r_len_b) ? r_len_a : r_len_b) - DW'(1);
        end
    end

    // Range of first-operand indices that feed term k
    assign w_lo = (i_mult && (r_k >= r_len_b)) ? (r_k - r_len_b + DW'(1)) : '0;
    assign w_hi = (r_len_a == '0) ? '0 : ((r_k < r_len_a) ? r_k : (r_len_a - DW'(1)));
    assign w_j  = r_k - r_i;
    assign w_issue_last = !i_mult || (r_i == w_hi);

    // Memory addressing
    assign w_wlen    = i_which_operand ? r_len_b : r_len_a;
    assign o_waddr   = w_wlen[AW-1:0];
    assign o_raddr_a = i_mult ? r_i[AW-1:0] : r_k[AW-1:0];
    assign o_raddr_b = i_mult ? w_j[AW-1:0] : r_k[AW-1:0];

    assign o_ready = (r_state == S_LOAD);

    // Issue one multiply-accumulate (or one add) per cycle while in the issue state
    always_comb begin
        o_issue.vld   = (r_state == S_ISSUE);
        o_issue.first = !i_mult || (r_i == w_lo);
        o_issue.last  = w_issue_last;
        o_issue.za    = i_mult ? (r_len_a == '0) : (r_k >= r_len_a);
        o_issue.zb    = i_mult ? 1'b0 : (r_k >= r_len_b);
    end

    assign o_term.degree  = r_k;
    assign o_term.last    = (r_k == w_kmax);
    assign o_term.dropped = r_overflow;

    // Next state: load coefficients, then walk the result terms
    always_comb begin
        n_state    = r_state;
        n_len_a    = r_len_a;
        n_len_b    = r_len_b;
        n_overflow = r_overflow;
        n_k        = r_k;
        n_i        = r_i;
        o_we_a     = 1'b0;
        o_we_b     = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (!i_which_operand) begin
                        if (r_len_a < w_cap) begin
                            o_we_a  = 1'b1;
                            n_len_a = r_len_a + DW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else begin
                        if (r_len_b < w_cap) begin
                            o_we_b  = 1'b1;
                            n_len_b = r_len_b + DW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end
                    if (i_which_operand && i_is_last) begin
                        n_k     = '0;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_out_free) begin
                    n_i     = w_lo;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_issue_last) begin
                    n_state = S_WAIT;
                end else begin
                    n_i = r_i + DW'(1);
                end
            end
            S_WAIT: begin
                if (i_term_done) begin
                    if (r_k == w_kmax) begin
                        n_len_a    = '0;
                        n_len_b    = '0;
                        n_overflow = 1'b0;
                        n_state    = S_LOAD;
                    end else begin
                        n_k     = r_k + DW'(1);
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Hold state, lengths and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_overflow <= 1'b0;
            r_k        <= '0;
            r_i        <= '0;
        end else begin
            r_state    <= n_state;
            r_len_a    <= n_len_a;
            r_len_b    <= n_len_b;
            r_overflow <= n_overflow;
            r_k        <= n_k;
            r_i        <= n_i;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pasm_datapath.sv -----
`default_nettype none

module pasm_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_mult,
    input  wire logic                         i_sub,
    input  wire pasm_pkg::t_issue             i_issue,
    input  wire pasm_pkg::t_term              i_term,
    input  wire logic [pasm_pkg::COEFF_W-1:0] i_rdata_a,
    input  wire logic [pasm_pkg::COEFF_W-1:0] i_rdata_b,
    output logic                              o_term_done,
    output logic                              o_out_free,
    // result request channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [pasm_pkg::RES_W-1:0]   o_result_coefficient,
    output logic      [pasm_pkg::DEG_W-1:0]   o_result_degree,
    output logic                              o_last_of_run,
    output logic                              o_terms_dropped
);

    localparam int CW = pasm_pkg::COEFF_W;
    localparam int RW = pasm_pkg::RES_W;

    pasm_pkg::t_issue     r_s1;
    pasm_pkg::t_issue     r_s2;
    logic [RW-1:0]        r_s2_val;
    logic [RW-1:0]        r_acc;
    logic                 r_out_valid;
    logic [RW-1:0]        r_out_coeff;
    logic [pasm_pkg::DEG_W-1:0] r_out_degree;
    logic                 r_out_last;
    logic                 r_out_dropped;

    logic signed [CW-1:0]   w_a;
    logic signed [CW-1:0]   w_b;
    logic signed [2*CW-1:0] w_prod;
    logic        [CW:0]     w_lin;
    logic        [RW-1:0]   w_val;
    logic        [RW-1:0]   w_sum;

    // Operands straight from the memory read registers, masked past the length
    assign w_a    = r_s1.za ? '0 : $signed(i_rdata_a);
    assign w_b    = r_s1.zb ? '0 : $signed(i_rdata_b);
    assign w_prod = w_a * w_b;
    assign w_lin  = i_sub ? ({w_a[CW-1], w_a} - {w_b[CW-1], w_b})
                          : ({w_a[CW-1], w_a} + {w_b[CW-1], w_b});
    assign w_val  = i_mult ? {{(RW-2*CW){w_prod[2*CW-1]}}, w_prod}
                           : {{(RW-CW-1){w_lin[CW]}}, w_lin};

    // Accumulate the terms of one result coefficient
    assign w_sum       = r_s2.first ? r_s2_val : (r_acc + r_s2_val);
    assign o_term_done = r_s2.vld && r_s2.last;
    assign o_out_free  = !r_out_valid || i_ready;

    // Advance the pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
        end
    end

    // Register the product or sum, and the running total
    always_ff @(posedge i_clk) begin
        r_s2_val <= w_val;
        if (r_s2.vld) begin
            r_acc <= w_sum;
        end
    end

    // Hold a finished term until the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_term_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_term_done) begin
            r_out_coeff   <= w_sum;
            r_out_degree  <= i_term.degree;
            r_out_last    <= i_term.last;
            r_out_dropped <= i_term.dropped;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_result_coefficient = r_out_coeff;
    assign o_result_degree      = r_out_degree;
    assign o_last_of_run        = r_out_last;
    assign o_terms_dropped      = r_out_dropped;

endmodule

`default_nettype wire

// ----- rtl/polynomial_add_sub_multiply_top.sv -----
`default_nettype none

// Polynomial add / subtract / multiply engine. Coefficients arrive one per
// request, lowest degree first, tagged with their operand and with a mark on
// each operand's final coefficient; each operand keeps up to MAX_TERMS of them
// in a synchronous memory with one write and one read port, further ones are
// dropped and reported on o_terms_dropped. While loading, o_ready stays high,
// so coefficients can be taken back to back. The final coefficient of the
// second operand starts a run that emits the result terms lowest degree
// first, with o_last_of_run on the final one; no input is taken during the
// run. Each term passes through a three-stage read, multiply and accumulate
// pipeline fed by the two coefficient memories, one product per cycle while a
// term is issued; the next term starts only once the previous one is done and
// the output register is free. The user must write the operation register
// only while no run is in progress; the block itself does not enforce this.
module polynomial_add_sub_multiply_top #(
    parameter int MAX_TERMS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // coefficient requests
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_which_operand,
    input  wire logic [pasm_pkg::COEFF_W-1:0] i_coefficient,
    input  wire logic                         i_is_last,
    // operation register
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [1:0]                   i_cfg_operation,
    // result requests
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [pasm_pkg::RES_W-1:0]   o_result_coefficient,
    output logic      [pasm_pkg::DEG_W-1:0]   o_result_degree,
    output logic                              o_last_of_run,
    output logic                              o_terms_dropped
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic [1:0]       r_operation;
    logic             w_mult;
    logic             w_sub;
    logic             w_out_free;
    logic             w_term_done;
    logic             w_we_a;
    logic             w_we_b;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr_a;
    logic [AW-1:0]    w_raddr_b;
    logic [pasm_pkg::COEFF_W-1:0] w_rdata_a;
    logic [pasm_pkg::COEFF_W-1:0] w_rdata_b;
    pasm_pkg::t_issue w_issue;
    pasm_pkg::t_term  w_term;

    // Hold the operation register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= pasm_pkg::OP_ADD;
        end else if (i_cfg_valid) begin
            r_operation <= i_cfg_operation;
        end
    end

    assign w_mult = (r_operation == pasm_pkg::OP_MUL);
    assign w_sub  = (r_operation == pasm_pkg::OP_SUB);

    pasm_seq #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_which_operand (i_which_operand),
        .i_is_last       (i_is_last),
        .i_mult          (w_mult),
        .i_out_free      (w_out_free),
        .i_term_done     (w_term_done),
        .o_we_a          (w_we_a),
        .o_we_b          (w_we_b),
        .o_waddr         (w_waddr),
        .o_raddr_a       (w_raddr_a),
        .o_raddr_b       (w_raddr_b),
        .o_issue         (w_issue),
        .o_term          (w_term)
    );

    pasm_coeff_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_coefficient),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    pasm_coeff_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_coefficient),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    pasm_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_mult               (w_mult),
        .i_sub                (w_sub),
        .i_issue              (w_issue),
        .i_term               (w_term),
        .i_rdata_a            (w_rdata_a),
        .i_rdata_b            (w_rdata_b),
        .o_term_done          (w_term_done),
        .o_out_free           (w_out_free),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_result_coefficient (o_result_coefficient),
        .o_result_degree      (o_result_degree),
        .o_last_of_run        (o_last_of_run),
        .o_terms_dropped      (o_terms_dropped)
    );

endmodule

`default_nettype wire

// ----- rtl/pasm_checker.sv -----
`default_nettype none

module pasm_assertions (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_ready,
    input wire logic                         i_which_operand,
    input wire logic [pasm_pkg::COEFF_W-1:0] i_coefficient,
    input wire logic                         i_is_last,
    input wire logic                         i_cfg_valid,
    input wire logic                         o_cfg_ready,
    input wire logic [1:0]                   i_cfg_operation,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [pasm_pkg::RES_W-1:0]   o_result_coefficient,
    input wire logic [pasm_pkg::DEG_W-1:0]   o_result_degree,
    input wire logic                         o_last_of_run,
    input wire logic                         o_terms_dropped
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_coefficient)
            && $stable(o_result_degree) && $stable(o_last_of_run)
            && $stable(o_terms_dropped))
        else $error("result changed while stalled");

    // The closing coefficient of the second operand starts a run
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_which_operand && i_is_last |=> !o_ready)
        else $error("input taken right after the run started");

    // No coefficient is taken while a run is still emitting terms
    a_mid_run_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> !o_ready)
        else $error("input ready in the middle of a run");

    // Nothing follows the final term until a new problem is loaded
    a_gap_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_of_run |=> !o_valid)
        else $error("result shown right after the final term");

endmodule

bind polynomial_add_sub_multiply_top pasm_assertions u_pasm_assertions (.*);

`default_nettype wire

// ----- tb/pasm_checker.sv -----
`timescale 1ns / 1ps

// Watch the coefficient, operation and result channels of the polynomial engine,
// keep a private copy of the operand lists and predict every result term.
module pasm_checker
    import pasm_pkg::*;
#(
    parameter int MAX_TERMS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // coefficient requests
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic               i_which_operand,
    input  wire logic [COEFF_W-1:0] i_coefficient,
    input  wire logic               i_is_last,
    // operation register writes
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [1:0]         i_cfg_operation,
    // result requests
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [RES_W-1:0]   i_result_coefficient,
    input  wire logic [DEG_W-1:0]   i_result_degree,
    input  wire logic               i_last_of_run,
    input  wire logic               i_terms_dropped,
    output int                      o_fail_count,
    output int                      o_terms_pending,
    output int                      o_terms_checked
);

    typedef struct packed {
        logic [RES_W-1:0] coef;
        logic [DEG_W-1:0] degree;
        logic             last;
        logic             dropped;
    } term_t;

    // Operand lists: index 0 is the first polynomial, 1 the second
    logic signed [COEFF_W-1:0] coeff_lists [2][MAX_TERMS];
    int unsigned               list_len [2];
    logic                      dropped_flag;
    logic [1:0]                operation;
    term_t                     result_terms [$];
    int                        fail_total    = 0;
    int                        checked_total = 0;

    initial begin
        o_fail_count    = 0;
        o_terms_pending = 0;
        o_terms_checked = 0;
    end

    // Queue one predicted term of the current run
    function automatic void queue_term(logic [RES_W-1:0] value, int unsigned degree,
                                       logic last);
        term_t t;
        t.coef    = value;
        t.degree  = DEG_W'(degree);
        t.last    = last;
        t.dropped = dropped_flag;
        result_terms.push_back(t);
    endfunction

    // Compute the whole run once the second operand is complete, then clear the lists
    function automatic void finish_problem();
        logic signed [RES_W-1:0] sums [2*MAX_TERMS];
        logic signed [RES_W-1:0] a, b;
        int unsigned             total, i, j;
        if (operation == OP_MUL) begin
            if (list_len[0] == 0) begin
                queue_term('0, 0, 1'b1);
            end else begin
                total = list_len[0] + list_len[1] - 1;
                for (i = 0; i < total; i++) sums[i] = '0;
                for (i = 0; i < list_len[0]; i++) begin
                    for (j = 0; j < list_len[1]; j++) begin
                        a = coeff_lists[0][i];
                        b = coeff_lists[1][j];
                        sums[i + j] = sums[i + j] + a * b;
                    end
                end
                for (i = 0; i < total; i++) queue_term(sums[i], i, i + 1 == total);
            end
        end else begin
            // add and subtract span the longer list, missing terms are zero
            total = (list_len[0] > list_len[1]) ? list_len[0] : list_len[1];
            for (i = 0; i < total; i++) begin
                a = '0;
                b = '0;
                if (i < list_len[0]) a = coeff_lists[0][i];
                if (i < list_len[1]) b = coeff_lists[1][i];
                queue_term((operation == OP_SUB) ? a - b : a + b, i, i + 1 == total);
            end
        end
        list_len[0]  = 0;
        list_len[1]  = 0;
        dropped_flag = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        term_t got, want;
        if (!i_rst_n) begin
            result_terms.delete();
            list_len[0]  = 0;
            list_len[1]  = 0;
            dropped_flag = 1'b0;
            operation    = OP_ADD;
        end else begin
            // Check each accepted result term against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = '{i_result_coefficient, i_result_degree, i_last_of_run, i_terms_dropped};
                if (result_terms.size() == 0) begin
                    $display("%0t: unexpected result term coef=%0d degree=%0d", $time,
                             $signed(got.coef), got.degree);
                    fail_total++;
                end else begin
                    want = result_terms.pop_front();
                    checked_total++;
                    if (got !== want) begin
                        $display("%0t: mismatch exp %0d/%0d/%b/%b got %0d/%0d/%b/%b %s",
                                 $time, $signed(want.coef), want.degree, want.last,
                                 want.dropped, $signed(got.coef), got.degree, got.last,
                                 got.dropped, "(coef/degree/last/dropped)");
                        fail_total++;
                    end
                end
            end

            // Track the operation register
            if (i_cfg_valid && i_cfg_ready) operation = i_cfg_operation;

            // Store the coefficient or drop it when the list is full
            if (i_in_valid && i_in_ready) begin
                if (list_len[i_which_operand] < MAX_TERMS) begin
                    coeff_lists[i_which_operand][list_len[i_which_operand]] = i_coefficient;
                    list_len[i_which_operand]++;
                end else begin
                    dropped_flag = 1'b1;
                end
                if (i_which_operand && i_is_last) finish_problem();
            end
        end
        o_fail_count    <= fail_total;
        o_terms_pending <= result_terms.size();
        o_terms_checked <= checked_total;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import pasm_pkg::*;

    localparam int         MAX_TERMS     = 32;
    localparam logic [1:0] OP_ALT_ADD    = 2'd3;  // spare code, behaves as add
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_LIMIT   = 40000;
    localparam int         PHASE_ITEMS   = 55;
    localparam logic [COEFF_W-1:0] MAX_COEFF = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam logic [COEFF_W-1:0] MIN_COEFF = {1'b1, {(COEFF_W-1){1'b0}}};

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               req_valid     = 1'b0;
    logic               req_ready;
    logic               req_which     = 1'b0;
    logic [COEFF_W-1:0] req_coeff     = '0;
    logic               req_last      = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_operation = OP_ADD;
    logic               res_valid;
    logic               res_ready     = 1'b0;
    logic [RES_W-1:0]   res_coeff;
    logic [DEG_W-1:0]   res_degree;
    logic               res_last;
    logic               res_dropped;

    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int coeffs_sent       = 0;
    int problems_sent     = 0;
    int overflow_problems = 0;
    int fail_count;
    int terms_pending;
    int terms_checked;

    polynomial_add_sub_multiply_top #(
        .MAX_TERMS(MAX_TERMS)
    ) i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (req_valid),
        .o_ready             (req_ready),
        .i_which_operand     (req_which),
        .i_coefficient       (req_coeff),
        .i_is_last           (req_last),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_operation     (cfg_operation),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_result_coefficient(res_coeff),
        .o_result_degree     (res_degree),
        .o_last_of_run       (res_last),
        .o_terms_dropped     (res_dropped)
    );

    pasm_checker #(
        .MAX_TERMS(MAX_TERMS)
    ) i_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (req_valid),
        .i_in_ready          (req_ready),
        .i_which_operand     (req_which),
        .i_coefficient       (req_coeff),
        .i_is_last           (req_last),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_operation     (cfg_operation),
        .i_out_valid         (res_valid),
        .i_out_ready         (res_ready),
        .i_result_coefficient(res_coeff),
        .i_result_degree     (res_degree),
        .i_last_of_run       (res_last),
        .i_terms_dropped     (res_dropped),
        .o_fail_count        (fail_count),
        .o_terms_pending     (terms_pending),
        .o_terms_checked     (terms_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at the rate of the current phase
    always @(posedge clk) begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Bias coefficients toward the extremes and small values
    function automatic logic [COEFF_W-1:0] random_coeff();
        case ($urandom_range(7))
            0: return MAX_COEFF;
            1: return MIN_COEFF;
            2: return COEFF_W'(int'($urandom_range(8)) - 4);
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // Mostly short operands, now and then one near or past the list size
    function automatic int pick_len(input int min_len);
        if ($urandom_range(99) < 5) return $urandom_range(MAX_TERMS + 3, MAX_TERMS - 4);
        return $urandom_range(6, min_len);
    endfunction

    // Send one coefficient request, with random idle cycles ahead of it
    task automatic send_coefficient(input logic which, input logic [COEFF_W-1:0] coeff,
                                    input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_which <= which;
        req_coeff <= coeff;
        req_last  <= last;
        do @(posedge clk); while (!req_ready);
        coeffs_sent++;
    endtask

    // Write the operation once every expected term has come back
    task automatic write_operation(input logic [1:0] op);
        req_valid <= 1'b0;
        do @(posedge clk); while (terms_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_operation <= op;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Send a well-formed problem, interleaving the operands, second last closes it
    task automatic run_problem(input int n, input int m);
        int a_left, b_left;
        a_left = n;
        b_left = m - 1;
        while (a_left + b_left > 0) begin
            if (a_left > 0 && (b_left == 0 || $urandom_range(3) != 0)) begin
                a_left--;
                send_coefficient(1'b0, random_coeff(), a_left == 0);
            end else begin
                b_left--;
                send_coefficient(1'b1, random_coeff(), 1'b0);
            end
        end
        send_coefficient(1'b1, random_coeff(), 1'b1);
        problems_sent++;
        if (n > MAX_TERMS || m > MAX_TERMS) overflow_problems++;
    endtask

    initial begin
        int p, phase_start, waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Add with extremes, second operand longer
        write_operation(OP_ADD);
        send_coefficient(1'b0, MAX_COEFF, 1'b0);
        send_coefficient(1'b0, MIN_COEFF, 1'b1);
        send_coefficient(1'b1, MIN_COEFF, 1'b0);
        send_coefficient(1'b1, MAX_COEFF, 1'b0);
        send_coefficient(1'b1, 16'h0001, 1'b1);

        // Subtract, first operand longer
        write_operation(OP_SUB);
        send_coefficient(1'b0, MIN_COEFF, 1'b0);
        send_coefficient(1'b0, 16'h0000, 1'b0);
        send_coefficient(1'b0, 16'hFFFF, 1'b1);
        send_coefficient(1'b1, MAX_COEFF, 1'b1);

        // Multiply with largest products, then empty first operand,
        // then a first operand extended after its last mark
        write_operation(OP_MUL);
        send_coefficient(1'b0, MIN_COEFF, 1'b0);
        send_coefficient(1'b0, MIN_COEFF, 1'b1);
        send_coefficient(1'b1, MIN_COEFF, 1'b0);
        send_coefficient(1'b1, MIN_COEFF, 1'b0);
        send_coefficient(1'b1, MIN_COEFF, 1'b1);
        send_coefficient(1'b1, 16'h1234, 1'b1);
        send_coefficient(1'b0, 16'h0003, 1'b1);
        send_coefficient(1'b0, 16'h0005, 1'b1);
        send_coefficient(1'b1, 16'h0002, 1'b1);

        // Spare operation code
        write_operation(OP_ALT_ADD);
        send_coefficient(1'b0, 16'h0001, 1'b1);
        send_coefficient(1'b1, 16'hFFFF, 1'b0);
        send_coefficient(1'b1, 16'h0002, 1'b1);

        // Random phases: vary operation and idling, mostly well-formed problems
        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case (p)
                0, 5:    write_operation(OP_ADD);
                1, 4, 7: write_operation(OP_MUL);
                2, 6:    write_operation(OP_SUB);
                default: write_operation(OP_ALT_ADD);
            endcase
            phase_start = coeffs_sent;
            // Force an overflowing operand on each side once
            if (p == 1) run_problem(MAX_TERMS + 2, 3);
            if (p == 6) run_problem(2, MAX_TERMS + 1);
            while (coeffs_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 12) begin
                    send_coefficient(1'($urandom_range(1)), random_coeff(),
                                     1'($urandom_range(1)));
                end else begin
                    run_problem(pick_len(0), pick_len(1));
                end
            end
        end

        // Drain outstanding terms, then let the block settle
        req_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (terms_pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (terms_pending != 0) begin
            $display("%0t: %0d expected result terms never arrived", $time, terms_pending);
        end
        $display("Sent %0d coefficients in %0d problems (%0d with dropped terms), all op codes,",
                 coeffs_sent, problems_sent, overflow_problems);
        $display("and checked %0d result terms under free-flow, gap and stall phases.",
                 terms_checked);
        if (fail_count == 0 && terms_pending == 0) begin
            $display("polynomial_add_sub_multiply_top test passed");
        end else begin
            $display("polynomial_add_sub_multiply_top test failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("polynomial_add_sub_multiply_top test failed");
        $finish;
    end

endmodule
